[rtl/lca_pkg.sv]
// Package for the tree lowest common ancestor block.
// Holds sizes, operation and status codes, the result word and the sequencer states.
// No dependencies.
package lca_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = 10;
    localparam int CNT_W     = 11;
    localparam int DEPTH_W   = 11;
    localparam int EDGE_CAP  = MAX_NODES - 1;
    localparam int EDGE_AW   = $clog2(EDGE_CAP);

    localparam logic [DEPTH_W-1:0] DEPTH_UNREACHED = '1;
    // mark entry that matches no dequeued node
    localparam logic [CNT_W-1:0]   STAMP_NONE      = '1;

    typedef enum logic [1:0] {
        OP_EDGE  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_BUILT = 3'd3,
        ST_UNREACHED = 3'd4
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [NODE_W-1:0]   ancestor;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP,
        S_DEQ0,
        S_DEQ1,
        S_DEQ2,
        S_EDGE,
        S_SCAN,
        S_QRD,
        S_QCHK,
        S_DONE
    } t_state;

endpackage

[rtl/tree_lowest_common_ancestor_top.sv]
// Lowest common ancestor block: one item in, one result word out. A build first
// clears every entry of the depth and mark memories, then, for every node it
// reaches, scans the E stored edges and the N nodes in use, one address at a time,
// through the edge and mark memories, each read at a single address. Each climb
// step of a query is one memory read and one compare.
// The result register lets the next word enter while a result waits.
// Depends on lca_pkg and lca_ctrl.
module tree_lowest_common_ancestor_top import lca_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // opcode[1:0], node_a[11:2], node_b[21:12], zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // ancestor[9:0], status[12:10], zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data   // node_count
);

    logic [CNT_W-1:0] r_node_count;
    logic [CNT_W-1:0] used_count;
    logic             r_out_valid;
    t_result          r_out;
    logic             done;
    logic             ack;
    t_result          result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_W'(1);
        end else if (i_cfg_valid) begin
            r_node_count <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_node_count == '0) begin
            used_count = CNT_W'(1);
        end else if (r_node_count > CNT_W'(MAX_NODES)) begin
            used_count = CNT_W'(MAX_NODES);
        end else begin
            used_count = r_node_count;
        end
    end

    lca_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_opcode     (i_s_tdata[1:0]),
        .i_node_a     (i_s_tdata[11:2]),
        .i_node_b     (i_s_tdata[21:12]),
        .i_node_count (used_count),
        .o_done       (done),
        .o_result     (result),
        .i_ack        (ack)
    );

    assign ack = done && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ack) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ack) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {3'b000, r_out};
    assign o_cfg_ready = 1'b1;

endmodule

[rtl/lca_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Standalone, no package use.
module lca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= mem[i_raddr_a];
        r_rdata_b <= mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[rtl/lca_ctrl.sv]
// Sequencer and memories of the ancestor block: edge store, depth, parent,
// walk queue and neighbor marks. Depends on lca_pkg and lca_ram.
module lca_ctrl import lca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_opcode,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic [CNT_W-1:0]  i_node_count,
    output logic              o_done,
    output t_result           o_result,
    input  logic              i_ack
);

    t_state              r_state, n_state;
    logic [NODE_W-1:0]   r_edge_total, n_edge_total;
    logic                r_built, n_built;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_rvld, n_rvld;
    logic [CNT_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0]    r_stamp, n_stamp;
    logic [NODE_W-1:0]   r_u, n_u;
    logic [DEPTH_W-1:0]  r_du, n_du;
    logic [NODE_W-1:0]   r_v, n_v;
    logic [NODE_W-1:0]   r_a, n_a;
    logic [NODE_W-1:0]   r_b, n_b;
    logic                r_first, n_first;
    t_result             r_res, n_res;

    // memory ports
    logic                   edge_we;
    logic [EDGE_AW-1:0]     edge_waddr, edge_raddr;
    logic [2*NODE_W-1:0]    edge_wdata, edge_q;
    logic                   dep_we;
    logic [NODE_W-1:0]      dep_waddr, dep_ra, dep_rb;
    logic [DEPTH_W-1:0]     dep_wdata, dep_qa, dep_qb;
    logic                   par_we;
    logic [NODE_W-1:0]      par_waddr, par_wdata, par_ra, par_rb, par_qa, par_qb;
    logic                   q_we;
    logic [NODE_W-1:0]      q_waddr, q_wdata, q_raddr, q_q;
    logic                   mk_we;
    logic [NODE_W-1:0]      mk_waddr, mk_raddr;
    logic [CNT_W-1:0]       mk_wdata, mk_q;

    // shared conditions
    logic                   in_range;
    logic                   store_full;
    logic                   edge_issue, scan_issue;
    logic [NODE_W-1:0]      edge_x, edge_y;
    logic                   edge_hit;
    logic                   scan_hit;
    logic                   q_unreached;

    lca_ram #(.WIDTH(2*NODE_W), .DEPTH(EDGE_CAP)) u_edge_ram (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_raddr_a(edge_raddr), .o_rdata_a(edge_q),
        .i_raddr_b(edge_raddr), .o_rdata_b()
    );

    lca_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_depth_ram (
        .i_clk(i_clk), .i_we(dep_we), .i_waddr(dep_waddr), .i_wdata(dep_wdata),
        .i_raddr_a(dep_ra), .o_rdata_a(dep_qa),
        .i_raddr_b(dep_rb), .o_rdata_b(dep_qb)
    );

    lca_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent_ram (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_waddr), .i_wdata(par_wdata),
        .i_raddr_a(par_ra), .o_rdata_a(par_qa),
        .i_raddr_b(par_rb), .o_rdata_b(par_qb)
    );

    lca_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr_a(q_raddr), .o_rdata_a(q_q),
        .i_raddr_b(q_raddr), .o_rdata_b()
    );

    lca_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_mark_ram (
        .i_clk(i_clk), .i_we(mk_we), .i_waddr(mk_waddr), .i_wdata(mk_wdata),
        .i_raddr_a(mk_raddr), .o_rdata_a(mk_q),
        .i_raddr_b(mk_raddr), .o_rdata_b()
    );

    always_comb begin
        in_range    = ({1'b0, i_node_a} < i_node_count) && ({1'b0, i_node_b} < i_node_count);
        store_full  = ({1'b0, r_edge_total} >= (i_node_count - CNT_W'(1)));
        edge_issue  = r_idx < {1'b0, r_edge_total};
        scan_issue  = r_idx < i_node_count;
        edge_x      = edge_q[NODE_W-1:0];
        edge_y      = edge_q[2*NODE_W-1:NODE_W];
        // edges touching nodes beyond the count are skipped by the walk
        edge_hit    = r_rvld && ({1'b0, edge_x} < i_node_count)
                      && ({1'b0, edge_y} < i_node_count)
                      && ((edge_x == r_u) || (edge_y == r_u));
        scan_hit    = r_rvld && (mk_q == r_stamp) && (dep_qa == DEPTH_UNREACHED)
                      && (r_tail < CNT_W'(MAX_NODES));
        q_unreached = (dep_qa == DEPTH_UNREACHED) || (dep_qb == DEPTH_UNREACHED);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_opcode == OP_BUILD) begin
                        n_state = S_SWEEP;
                    end else if (i_opcode == OP_QUERY && in_range && r_built) begin
                        n_state = S_QRD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SWEEP: begin
                if (r_idx == CNT_W'(MAX_NODES - 1)) begin
                    n_state = S_DEQ0;
                end
            end
            S_DEQ0: n_state = S_DEQ1;
            S_DEQ1: n_state = S_DEQ2;
            S_DEQ2: n_state = S_EDGE;
            S_EDGE: begin
                if (!edge_issue && !r_rvld) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!scan_issue && !r_rvld) begin
                    n_state = (r_head < r_tail) ? S_DEQ0 : S_DONE;
                end
            end
            S_QRD: n_state = S_QCHK;
            S_QCHK: begin
                if ((r_first && q_unreached) || (r_a == r_b)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_QRD;
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_edge_total = r_edge_total;
        n_built      = r_built;
        n_idx        = r_idx;
        n_rvld       = r_rvld;
        n_head       = r_head;
        n_tail       = r_tail;
        n_stamp      = r_stamp;
        n_u          = r_u;
        n_du         = r_du;
        n_v          = r_v;
        n_a          = r_a;
        n_b          = r_b;
        n_first      = r_first;
        n_res        = r_res;

        edge_we    = 1'b0;
        edge_waddr = r_edge_total[EDGE_AW-1:0];
        edge_wdata = {i_node_b, i_node_a};
        edge_raddr = r_idx[EDGE_AW-1:0];
        dep_we     = 1'b0;
        dep_waddr  = r_v;
        dep_wdata  = r_du + DEPTH_W'(1);
        dep_ra     = r_idx[NODE_W-1:0];
        dep_rb     = r_b;
        par_we     = 1'b0;
        par_waddr  = r_v;
        par_wdata  = r_u;
        par_ra     = r_a;
        par_rb     = r_b;
        q_we       = 1'b0;
        q_waddr    = r_tail[NODE_W-1:0];
        q_wdata    = r_v;
        q_raddr    = r_head[NODE_W-1:0];
        mk_we      = 1'b0;
        mk_waddr   = (edge_x == r_u) ? edge_y : edge_x;
        mk_wdata   = r_stamp;
        mk_raddr   = r_idx[NODE_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                n_res.ancestor = '0;
                n_res.status   = ST_OK;
                n_idx          = '0;
                n_rvld         = 1'b0;
                if (i_valid) begin
                    priority if (i_opcode == OP_EDGE) begin
                        if (!in_range) begin
                            n_res.status = ST_RANGE;
                        end else if (store_full) begin
                            n_res.status = ST_FULL;
                        end else begin
                            edge_we      = 1'b1;
                            n_edge_total = r_edge_total + NODE_W'(1);
                            n_built      = 1'b0;
                        end
                    end else if (i_opcode == OP_BUILD) begin
                        n_head = '0;
                        n_tail = CNT_W'(1);
                    end else if (i_opcode == OP_QUERY) begin
                        if (!in_range) begin
                            n_res.status = ST_RANGE;
                        end else if (!r_built) begin
                            n_res.status = ST_NOT_BUILT;
                        end else begin
                            n_a     = i_node_a;
                            n_b     = i_node_b;
                            n_first = 1'b1;
                        end
                    end else begin
                        n_res.status = ST_RANGE;
                    end
                end
            end
            S_SWEEP: begin
                // clear depth and marks; root gets depth zero and heads the queue
                dep_we    = 1'b1;
                dep_waddr = r_idx[NODE_W-1:0];
                dep_wdata = (r_idx == '0) ? '0 : DEPTH_UNREACHED;
                mk_we     = 1'b1;
                mk_waddr  = r_idx[NODE_W-1:0];
                mk_wdata  = STAMP_NONE;
                q_we      = (r_idx == '0);
                q_waddr   = '0;
                q_wdata   = '0;
                n_idx     = r_idx + CNT_W'(1);
            end
            S_DEQ0: begin
                q_raddr = r_head[NODE_W-1:0];
            end
            S_DEQ1: begin
                n_u     = q_q;
                dep_ra  = q_q;
                n_stamp = r_head;
                n_head  = r_head + CNT_W'(1);
            end
            S_DEQ2: begin
                n_du   = dep_qa;
                n_idx  = '0;
                n_rvld = 1'b0;
            end
            S_EDGE: begin
                n_rvld = edge_issue;
                if (edge_issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                mk_we = edge_hit;
                if (!edge_issue && !r_rvld) begin
                    n_idx = '0;
                end
            end
            S_SCAN: begin
                n_rvld = scan_issue;
                n_v    = r_idx[NODE_W-1:0];
                if (scan_issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (scan_hit) begin
                    dep_we = 1'b1;
                    par_we = 1'b1;
                    q_we   = 1'b1;
                    n_tail = r_tail + CNT_W'(1);
                end
                if (!scan_issue && !r_rvld && !(r_head < r_tail)) begin
                    n_built = 1'b1;
                end
            end
            S_QRD: begin
                dep_ra = r_a;
                dep_rb = r_b;
            end
            S_QCHK: begin
                n_first = 1'b0;
                if (r_first && q_unreached) begin
                    n_res.status = ST_UNREACHED;
                end else if (r_a == r_b) begin
                    n_res.ancestor = r_a;
                end else if (dep_qa > dep_qb) begin
                    n_a = par_qa;
                end else if (dep_qb > dep_qa) begin
                    n_b = par_qb;
                end else begin
                    n_a = par_qa;
                    n_b = par_qb;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_edge_total <= '0;
            r_built      <= 1'b0;
            r_rvld       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_edge_total <= n_edge_total;
            r_built      <= n_built;
            r_rvld       <= n_rvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_head  <= n_head;
        r_tail  <= n_tail;
        r_stamp <= n_stamp;
        r_u     <= n_u;
        r_du    <= n_du;
        r_v     <= n_v;
        r_a     <= n_a;
        r_b     <= n_b;
        r_first <= n_first;
        r_res   <= n_res;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = r_res;

endmodule

[rtl/lca_checker.sv]
// Port-level checks for the ancestor block, bound to the top level.
// Depends on lca_pkg.
module lca_checker import lca_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[12:10] <= ST_UNREACHED)
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[12:10] != ST_OK) |-> o_m_tdata[9:0] == '0)
        else $error("failed item carries nonzero ancestor");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second word taken while one is in work");

endmodule

bind tree_lowest_common_ancestor_top lca_checker u_lca_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
